// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

  localparam int BLOCK_W = 12;
  localparam int TOTAL_W = 13;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    status_t            status;
  } res_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FIX   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_PUSH  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

endpackage

// ===== hw/rtl/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bba_find.sv =====
module bba_find #(
  parameter int WORD_BITS = 32,
  parameter int BIT_W     = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] vec,
  output logic                 any,
  output logic [BIT_W-1:0]     idx
);

  localparam int GROUPS = (WORD_BITS + 7) / 8;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [GROUPS*8-1:0] pad;
  logic [GROUPS-1:0]   grp_any;
  logic [GW-1:0]       gsel;
  logic [7:0]          sub;
  logic [2:0]          jsel;

  assign pad = (GROUPS*8)'(vec);

  // lowest non-empty byte group first, then lowest bit inside it
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |pad[g*8 +: 8];
    end
    gsel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = GW'(g);
      end
    end
  end

  always_comb begin
    sub  = pad[gsel*8 +: 8];
    jsel = '0;
    for (int j = 7; j >= 0; j--) begin
      if (sub[j]) begin
        jsel = 3'(j);
      end
    end
  end

  assign any = |grp_any;
  assign idx = BIT_W'({gsel, jsel});

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
module bba_ctrl
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 4096,
  parameter int WORD_BITS  = 32,
  parameter int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS,
  parameter int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  parameter int BIT_W      = $clog2(WORD_BITS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TOTAL_W-1:0]   lim,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [BLOCK_W-1:0]   in_block_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output logic [WORD_BITS-1:0] mem_wr_data,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  logic [WORD_BITS-1:0] mem_rd_data,
  output logic [WORD_BITS-1:0] free_vec,
  input  logic                 find_any,
  input  logic [BIT_W-1:0]     find_idx
);

  localparam int BASE_W = TOTAL_W + 1;
  localparam int DIV_S  = 24;
  localparam int PROD_W = BLOCK_W + DIV_S;
  localparam int RECIP  = (1 << DIV_S) / WORD_BITS;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [BLOCK_W-1:0]   blk_r, blk_nxt;
  logic [BLOCK_W-1:0]   q_r, q_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [AW-1:0]        word_r, word_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  res_t                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;

  logic [BASE_W-1:0]    lim_ext;
  logic [BASE_W-1:0]    rem;
  logic [BASE_W-1:0]    base_step;
  logic [WORD_BITS-1:0] valid_mask;
  logic [PROD_W-1:0]    div_prod;
  logic [BLOCK_W-1:0]   back;
  logic [BLOCK_W-1:0]   r0;
  logic [BLOCK_W-1:0]   q_fix;
  logic [BLOCK_W-1:0]   r_fix;
  logic                 in_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign lim_ext   = BASE_W'(lim);
  assign rem       = lim_ext - base_r;
  assign base_step = base_r + BASE_W'(WORD_BITS);

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      valid_mask[i] = (BASE_W'(i) < rem);
    end
  end

  assign free_vec = ~mem_rd_data & valid_mask;

  // word index by reciprocal, corrected by one compare and subtract
  assign div_prod = PROD_W'(in_block_number) * PROD_W'(RECIP);
  assign back     = q_r * BLOCK_W'(WORD_BITS);
  assign r0       = blk_r - back;

  always_comb begin
    if (r0 >= BLOCK_W'(WORD_BITS)) begin
      q_fix = q_r + 1'b1;
      r_fix = r0 - BLOCK_W'(WORD_BITS);
    end else begin
      q_fix = q_r;
      r_fix = r0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    blk_nxt       = blk_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = word_r;
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          blk_nxt          = in_block_number;
          res_nxt.block    = '0;
          if (in_mode == MODE_ALLOC) begin
            if (lim == '0) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_PUSH;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              word_nxt    = '0;
              base_nxt    = '0;
              state_nxt   = S_SCAN;
            end
          end else begin
            if (BASE_W'(in_block_number) >= lim_ext) begin
              res_nxt.status = ST_OUT_OF_RANGE;
              state_nxt      = S_PUSH;
            end else begin
              q_nxt     = div_prod[PROD_W-1:DIV_S];
              state_nxt = S_FIX;
            end
          end
        end
      end
      S_FIX: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(q_fix);
        word_nxt    = AW'(q_fix);
        bit_nxt     = BIT_W'(r_fix);
        state_nxt   = S_FREE;
      end
      S_SCAN: begin
        if (find_any) begin
          mem_wr_en      = 1'b1;
          mem_wr_data    = mem_rd_data | (WORD_BITS'(1) << find_idx);
          res_nxt.block  = BLOCK_W'(base_r + BASE_W'(find_idx));
          res_nxt.status = ST_OK;
          state_nxt      = S_PUSH;
        end else if (base_step >= lim_ext) begin
          res_nxt.block  = '0;
          res_nxt.status = ST_FULL;
          state_nxt      = S_PUSH;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = word_r + 1'b1;
          word_nxt    = word_r + 1'b1;
          base_nxt    = base_step;
        end
      end
      S_FREE: begin
        if (!mem_rd_data[bit_r]) begin
          res_nxt.status = ST_ALREADY_FREE;
        end else begin
          mem_wr_en      = 1'b1;
          mem_wr_data    = mem_rd_data & ~(WORD_BITS'(1) << bit_r);
          res_nxt.status = ST_OK;
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    q_r       <= q_nxt;
    bit_r     <= bit_nxt;
    word_r    <= word_nxt;
    base_r    <= base_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

// ===== hw/rtl/bitmap_block_allocator_top.sv =====
// first-fit block allocator over a one-bit-per-block usage bitmap
// input channel: in_mode (0 allocate, 1 free) and in_block_number, one transfer per request
// result channel: out_allocated_block and out_status, exactly one transfer per request
// config channel: cfg_total_blocks sets the block count, taken on any cfg transfer;
//   values above NUM_BLOCKS act as NUM_BLOCKS
// one request is in flight at a time; the bitmap sits in a single ram read one word a cycle
// allocate: the scan reads bitmap words in order from word zero until a free bit turns up,
//   at most ceil(count / WORD_BITS) words, all through the ram read port
// free: word index, read, update, result; an out-of-range free or a zero-count allocate goes straight to the result
// the result follows the ram write-back, through the push state into a registered output stage
// a stalled receiver holds the result in the output stage; the next request is still
//   accepted and worked, and then waits in the controller until the stage empties
// reset: synchronous, active low; block count returns to 4096, then a clearing pass writes
//   all ceil(NUM_BLOCKS / WORD_BITS) bitmap words to zero while in_ready stays low;
//   config transfers are taken throughout
module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [BLOCK_W-1:0] in_block_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BLOCK_W-1:0] out_allocated_block,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TOTAL_W-1:0] cfg_total_blocks
);

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int NB_W      = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W     = (NB_W > TOTAL_W) ? NB_W : TOTAL_W;

  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   total_nxt;
  logic [TOTAL_W-1:0]   lim;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic [WORD_BITS-1:0] free_vec;
  logic                 find_any;
  logic [BIT_W-1:0]     find_idx;
  res_t                 out_res;

  // config register, always ready
  assign cfg_ready = 1'b1;
  assign total_nxt = (cfg_valid && cfg_ready) ? cfg_total_blocks : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else begin
      total_r <= total_nxt;
    end
  end

  // saturate the count at the bitmap capacity
  assign lim = (CMP_W'(total_r) > CMP_W'(NUM_BLOCKS)) ? TOTAL_W'(NUM_BLOCKS) : total_r;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // lowest free bit of the word under scan
  bba_find #(
    .WORD_BITS (WORD_BITS)
  ) u_find (
    .vec (free_vec),
    .any (find_any),
    .idx (find_idx)
  );

  bba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .lim             (lim),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_block_number (in_block_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_res         (out_res),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data),
    .free_vec        (free_vec),
    .find_any        (find_any),
    .find_idx        (find_idx)
  );

  assign out_allocated_block = out_res.block;
  assign out_status          = out_res.status;

  // the ram is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("bitmap ram read and write overlap");

  // one request at a time: no transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in flight");

  // a failed request reports block zero; a successful free gives zero too but is not checked here
  a_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_allocated_block == '0))
    else $error("nonzero block number with failure status");

  // no ram write-back while no request is being worked or cleared
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && $past(in_ready)) |-> !mem_wr_en)
    else $error("bitmap written while idle");

endmodule

// ===== tb/bitmap_block_allocator_top_test.sv =====
`timescale 1ns / 1ps

module bitmap_block_allocator_top_test;
  import bba_pkg::*;

  localparam int CAPACITY   = 4096;
  localparam int HOLD_CYCLES = 400;

  // mirror of the usage bitmap and block count, with the replies still owed
  class usage_map_tracker;
    bit [CAPACITY-1:0] used_map;
    bit [TOTAL_W-1:0]  block_count;
    res_t              awaited_replies[$];
    int                errors;

    function new();
      used_map    = '0;
      block_count = TOTAL_RESET;
      errors      = 0;
    endfunction

    function void set_count(bit [TOTAL_W-1:0] v);
      block_count = v;
    endfunction

    // counts above capacity saturate
    function int limit();
      return (block_count > CAPACITY) ? CAPACITY : int'(block_count);
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    // some used block below the count, or -1 when there is none
    function int pick_used();
      int lim;
      int start;
      int b;
      lim = limit();
      if (lim == 0) return -1;
      start = $urandom_range(lim - 1);
      for (int i = 0; i < lim; i++) begin
        b = (start + i) % lim;
        if (used_map[b]) return b;
      end
      return -1;
    endfunction

    // first-fit allocate or free, applied at the input transfer
    function void note_request(logic mode, logic [BLOCK_W-1:0] blk);
      res_t r;
      int   lim;
      lim      = limit();
      r.block  = '0;
      r.status = ST_FULL;
      if (mode == MODE_ALLOC) begin
        for (int b = 0; b < lim; b++) begin
          if (!used_map[b]) begin
            used_map[b] = 1'b1;
            r.block     = b[BLOCK_W-1:0];
            r.status    = ST_OK;
            break;
          end
        end
      end else if (blk >= lim) begin
        // range is checked before the free bit
        r.status = ST_OUT_OF_RANGE;
      end else if (!used_map[blk]) begin
        r.status = ST_ALREADY_FREE;
      end else begin
        used_map[blk] = 1'b0;
        r.status      = ST_OK;
      end
      awaited_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("%0t allocator check failed: %s", $realtime, what);
      errors++;
    endtask

    task check_reply(logic [BLOCK_W-1:0] got_block, logic [1:0] got_status);
      res_t want;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing owed: block %0d status %0d",
                                  got_block, got_status));
        return;
      end
      want = awaited_replies.pop_front();
      if (got_status !== want.status)
        report_mismatch($sformatf("status %0d, wanted %s", got_status, want.status.name()));
      if (got_block !== want.block)
        report_mismatch($sformatf("block %0d, wanted %0d", got_block, want.block));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic [BLOCK_W-1:0] in_block_number;
  logic               out_valid;
  logic               out_ready;
  logic [BLOCK_W-1:0] out_allocated_block;
  logic [1:0]         out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [TOTAL_W-1:0] cfg_total_blocks;

  usage_map_tracker tracker = new();

  // idle_pct and quiet shared by both sides, hold_req for the receiver only
  int idle_pct;
  bit quiet;
  bit hold_req;

  bitmap_block_allocator_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_allocated_block (out_allocated_block),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_total_blocks    (cfg_total_blocks)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: sample every transfer at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_reply(out_allocated_block, out_status);
  end

  // receiver readiness: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done  = 1'b1;
      end else if (stall_left == 0 && !quiet && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // one request; valid stays up from the previous transfer unless a gap is taken
  task automatic send_request(logic mode, logic [BLOCK_W-1:0] blk);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_mode         = mode;
    in_block_number = blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(mode, blk);
  endtask

  // drop the input, let every owed reply drain, then write the block count
  task automatic set_block_count(logic [TOTAL_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid        = 1'b1;
    cfg_total_blocks = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_count(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [TOTAL_W-1:0] pick_count();
    case ($urandom_range(11))
      0:       return '0;
      1:       return TOTAL_W'(1);
      2:       return TOTAL_W'($urandom_range(2, 31));
      3:       return TOTAL_W'(32);
      4:       return TOTAL_W'(33);
      5:       return TOTAL_W'(64);
      6:       return TOTAL_W'($urandom_range(65, 300));
      7:       return TOTAL_W'(CAPACITY - 1);
      8:       return TOTAL_W'(CAPACITY);
      9:       return TOTAL_W'($urandom_range(CAPACITY + 1, 8190));
      10:      return '1;
      default: return TOTAL_W'($urandom_range(0, 8191));
    endcase
  endfunction

  // mostly allocations and frees of used blocks, the rest noise and edge frees
  task automatic random_request(int alloc_pct);
    int                 sel;
    int                 u;
    int                 lim;
    logic [BLOCK_W-1:0] blk;
    lim = tracker.limit();
    if ($urandom_range(99) < alloc_pct) begin
      send_request(MODE_ALLOC, BLOCK_W'($urandom));
    end else begin
      sel = $urandom_range(9);
      u   = tracker.pick_used();
      if (sel < 6 && u >= 0) blk = BLOCK_W'(u);
      else if (sel == 6)     blk = BLOCK_W'(lim);
      else if (sel == 7)     blk = BLOCK_W'(lim - 1);
      else                   blk = BLOCK_W'($urandom);
      send_request(MODE_FREE, blk);
    end
  endtask

  initial begin
    int sent;
    int phase;
    int alloc_pct;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = MODE_ALLOC;
    in_block_number  = '0;
    cfg_valid        = 1'b0;
    cfg_total_blocks = '0;
    idle_pct         = 20;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    sent             = 0;
    phase            = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset count, block zero reuse, double free
    send_request(MODE_ALLOC, '1);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, '0);
    send_request(MODE_FREE, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, '1);
    // zero count: nothing to allocate, every free out of range
    set_block_count('0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, '0);
    // count above capacity saturates
    set_block_count('1);
    send_request(MODE_FREE, '1);
    send_request(MODE_ALLOC, '0);
    // shrunk count: used bits above it stay put and are unreachable
    set_block_count(TOTAL_W'(2));
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, BLOCK_W'(2));
    send_request(MODE_FREE, BLOCK_W'(1));
    send_request(MODE_ALLOC, '0);
    set_block_count(TOTAL_W'(1));
    send_request(MODE_FREE, BLOCK_W'(1));
    send_request(MODE_ALLOC, '0);
    // count raised again, stranded blocks come back
    set_block_count(TOTAL_W'(CAPACITY));
    send_request(MODE_FREE, BLOCK_W'(2));
    send_request(MODE_FREE, BLOCK_W'(1));
    send_request(MODE_FREE, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 12'hAAA);
    send_request(MODE_FREE, 12'h555);

    // random phases, each under its own block count and mix
    while (sent < 1100) begin
      set_block_count(pick_count());
      if (sent >= 960) quiet = 1'b1;
      idle_pct  = quiet ? 0 : $urandom_range(0, 35);
      alloc_pct = $urandom_range(25, 85);
      // long receiver hold-off so the block backs up into its input
      if (phase == 2) hold_req = 1'b1;
      repeat ($urandom_range(40, 120)) begin
        random_request(alloc_pct);
        sent++;
      end
      phase++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    // room for any stray reply after the last one owed
    repeat (200) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("bitmap_block_allocator_top: match");
    end else begin
      $display("bitmap_block_allocator_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("bitmap_block_allocator_top: mismatch");
    $finish;
  end

endmodule
